// ===== src/position_delta_packet_encoder_top_assert.svh =====
// Assertion macros of the position delta packet encoder RTL.
// Depends on nothing; included by the top level, the one file that carries assertions.
`ifndef POSITION_DELTA_PACKET_ENCODER_TOP_ASSERT_SVH
`define POSITION_DELTA_PACKET_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define PDPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdpe: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define PDPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdpe: next-cycle check failed");

`endif

// ===== src/pdpe_pkg.sv =====
// Types, constants and helpers of the position delta packet encoder.
// Depends on nothing; imported by pdpe_predict, pdpe_select and the top level.
package pdpe_pkg;

    // Width of a position difference: 32-bit minus 32-bit minus prediction.
    localparam int D_W = 34;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 1'b1;
    localparam logic [15:0] KEY_INTERVAL_RST = 16'd30;
    localparam logic [4:0]  OUT_CAPACITY_RST = 5'd16;

    // Frame time handling: nominal frame and the range that gives factors 128..512.
    localparam logic [15:0] T_NOMINAL = 16'd16660;
    localparam logic [15:0] T_LOW     = 16'd8330;
    localparam logic [15:0] T_HIGH    = 16'd33320;

    // floor(t * 64 / 4165) by reciprocal: q = (t * F_RECIP) >> F_SHIFT, then one correction.
    localparam logic [20:0] F_RECIP   = 21'd1031204;
    localparam int          F_SHIFT   = 26;
    localparam logic [12:0] F_DIVISOR = 13'd4165;

    // floor(n / 10) for n below 2^19 by reciprocal.
    localparam logic [18:0] Q10_RECIP  = 19'd419431;
    localparam int          Q10_SHIFT  = 22;
    localparam logic [4:0]  ROUND_HALF = 5'd5;

    // Velocity and mode thresholds.
    localparam logic [23:0] VEL_SLOW_LIMIT = 24'd100;
    localparam logic [14:0] VEL_SQ_LIMIT   = 15'd10000;
    localparam logic [4:0]  ZTHR_SLOW      = 5'd20;
    localparam logic [4:0]  ZTHR_FAST      = 5'd5;
    localparam logic [D_W-1:0] D8_LIMIT    = 34'd1270;
    localparam logic [D_W-1:0] D16_LIMIT   = 34'd327670;

    // Packet modes as carried in flags bits 1:0.
    typedef enum logic [1:0] {
        MODE_KEY  = 2'd0,
        MODE_D16  = 2'd1,
        MODE_D8   = 2'd2,
        MODE_ZERO = 2'd3
    } t_mode;

    // Plain and predicted differences leaving the prediction stages.
    typedef struct packed {
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic signed [D_W-1:0] pdx;
        logic signed [D_W-1:0] pdy;
        logic                  vslow;
    } t_pred_bus;

    // Mode decision and quantised magnitudes leaving the selection stages.
    typedef struct packed {
        t_mode       mode;
        logic        pred;
        logic        key;
        logic [14:0] qx;
        logic [14:0] qy;
        logic        negx;
        logic        negy;
    } t_sel_bus;

    // Total packet length in bytes for each mode.
    function automatic logic [4:0] f_mode_len(input t_mode m);
        logic [4:0] len;
        case (m)
            MODE_KEY:  len = 5'd16;
            MODE_D16:  len = 5'd12;
            MODE_D8:   len = 5'd10;
            MODE_ZERO: len = 5'd8;
            default:   len = 5'd16;
        endcase
        return len;
    endfunction

endpackage

// ===== src/pdpe_if.sv =====
// Valid/ready channel interfaces for position updates and encoded packets.
// Depends on nothing; used by the top level of the encoder.
interface pdpe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] last_x;
    logic signed [31:0] last_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [15:0]        sequence_req;
    logic [31:0]        timestamp;
    logic               force_key;
    logic [19:0]        frame_time_us;

    modport source (
        output valid, pos_x, pos_y, last_x, last_y, vel_x, vel_y,
               sequence_req, timestamp, force_key, frame_time_us,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, last_x, last_y, vel_x, vel_y,
               sequence_req, timestamp, force_key, frame_time_us,
        output ready
    );
endinterface

interface pdpe_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [4:0]  packet_length;
    logic [3:0]  flags;
    logic [15:0] out_sequence;
    logic [31:0] out_timestamp;
    logic [31:0] payload_x;
    logic [31:0] payload_y;

    modport source (
        output valid, status, packet_length, flags, out_sequence, out_timestamp,
               payload_x, payload_y,
        input  ready
    );
    modport sink (
        input  valid, status, packet_length, flags, out_sequence, out_timestamp,
               payload_x, payload_y,
        output ready
    );
endinterface

// ===== src/pdpe_key_div.sv =====
// Pipelined remainder of the sequence number by the keyframe interval.
// Four stages of four restoring division steps each; no package needed.
module pdpe_key_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_seq,
    input  logic        i_force,
    input  logic [15:0] i_interval,
    output logic        o_key
);
    localparam int STAGES = 4;
    localparam int STEP_BITS = 4;
    localparam int SEQ_W = 16;

    logic [SEQ_W-1:0] r_rem   [STAGES];
    logic [SEQ_W-1:0] r_seq   [STAGES];
    logic             r_force [STAGES];
    logic [SEQ_W-1:0] n_rem   [STAGES];

    // Four restoring steps: shift in the next dividend bit, subtract when it fits.
    function automatic logic [SEQ_W-1:0] f_div_step(
        input logic [SEQ_W-1:0]     rem,
        input logic [STEP_BITS-1:0] bits,
        input logic [SEQ_W-1:0]     div
    );
        logic [SEQ_W:0]   acc;
        logic [SEQ_W-1:0] r;
        r = rem;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            acc = {r, bits[i]};
            if (acc >= {1'b0, div}) begin
                acc = acc - {1'b0, div};
            end
            r = acc[SEQ_W-1:0];
        end
        return r;
    endfunction

    // Each stage takes the next four bits of the sequence number, high bits first.
    always_comb begin
        n_rem[0] = f_div_step('0, i_seq[SEQ_W-1 -: STEP_BITS], i_interval);
        for (int s = 1; s < STAGES; s++) begin
            n_rem[s] = f_div_step(r_rem[s-1], r_seq[s-1][SEQ_W-1-STEP_BITS*s -: STEP_BITS],
                                  i_interval);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= n_rem[0];
            r_seq[0]   <= i_seq;
            r_force[0] <= i_force;
            for (int s = 1; s < STAGES; s++) begin
                r_rem[s]   <= n_rem[s];
                r_seq[s]   <= r_seq[s-1];
                r_force[s] <= r_force[s-1];
            end
        end
    end

    // An interval of zero never forces a keyframe by sequence number.
    assign o_key = r_force[STAGES-1] || (i_interval != '0 && r_rem[STAGES-1] == '0);

endmodule

// ===== src/pdpe_predict.sv =====
// Velocity factor, dead-reckoning prediction and plain/predicted differences.
// Six register stages; depends on pdpe_pkg.
module pdpe_predict (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_last_x,
    input  logic signed [31:0]  i_last_y,
    input  logic signed [23:0]  i_vel_x,
    input  logic signed [23:0]  i_vel_y,
    input  logic [19:0]         i_frame_time_us,
    output pdpe_pkg::t_pred_bus o_bus
);
    import pdpe_pkg::*;

    // Stage 1: differences, clamped frame time, small-velocity test.
    logic signed [32:0] r1_dx, r1_dy;
    logic signed [23:0] r1_vx, r1_vy;
    logic [15:0]        r1_tc;
    logic [6:0]         r1_avx, r1_avy;
    logic               r1_vlo;
    logic [15:0]        n1_tc;
    logic [23:0]        n1_avx, n1_avy;

    always_comb begin
        if (i_frame_time_us <= 20'd1) begin
            n1_tc = T_NOMINAL;
        end else if (i_frame_time_us < {4'b0, T_LOW}) begin
            n1_tc = T_LOW;
        end else if (i_frame_time_us > {4'b0, T_HIGH}) begin
            n1_tc = T_HIGH;
        end else begin
            n1_tc = i_frame_time_us[15:0];
        end
        n1_avx = i_vel_x[23] ? 24'(-i_vel_x) : 24'(i_vel_x);
        n1_avy = i_vel_y[23] ? 24'(-i_vel_y) : 24'(i_vel_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx  <= 33'(i_pos_x) - 33'(i_last_x);
            r1_dy  <= 33'(i_pos_y) - 33'(i_last_y);
            r1_vx  <= i_vel_x;
            r1_vy  <= i_vel_y;
            r1_tc  <= n1_tc;
            r1_avx <= n1_avx[6:0];
            r1_avy <= n1_avy[6:0];
            r1_vlo <= (n1_avx < VEL_SLOW_LIMIT) && (n1_avy < VEL_SLOW_LIMIT);
        end
    end

    // Stage 2: first estimate of the factor, squared velocity compare.
    logic signed [32:0] r2_dx, r2_dy;
    logic signed [23:0] r2_vx, r2_vy;
    logic [15:0]        r2_tc;
    logic [9:0]         r2_q;
    logic               r2_vslow;
    logic [36:0]        n2_prod;
    logic [13:0]        n2_sqx, n2_sqy;
    logic [14:0]        n2_sqsum;

    always_comb begin
        n2_prod  = r1_tc * F_RECIP;
        n2_sqx   = r1_avx * r1_avx;
        n2_sqy   = r1_avy * r1_avy;
        n2_sqsum = {1'b0, n2_sqx} + {1'b0, n2_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dx    <= r1_dx;
            r2_dy    <= r1_dy;
            r2_vx    <= r1_vx;
            r2_vy    <= r1_vy;
            r2_tc    <= r1_tc;
            r2_q     <= n2_prod[F_SHIFT +: 10];
            r2_vslow <= r1_vlo && (n2_sqsum < VEL_SQ_LIMIT);
        end
    end

    // Stage 3: the estimate is at most one low; correct it from the remainder.
    logic signed [32:0] r3_dx, r3_dy;
    logic signed [23:0] r3_vx, r3_vy;
    logic [9:0]         r3_f;
    logic               r3_vslow;
    logic [22:0]        n3_back;
    logic [21:0]        n3_rem;

    always_comb begin
        n3_back = r2_q * F_DIVISOR;
        n3_rem  = {r2_tc, 6'b0} - n3_back[21:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_dx    <= r2_dx;
            r3_dy    <= r2_dy;
            r3_vx    <= r2_vx;
            r3_vy    <= r2_vy;
            r3_f     <= r2_q + 10'(n3_rem >= {9'b0, F_DIVISOR});
            r3_vslow <= r2_vslow;
        end
    end

    // Stage 4: velocity times the Q8 factor.
    logic signed [32:0] r4_dx, r4_dy;
    logic signed [34:0] r4_px, r4_py;
    logic               r4_vslow;
    logic signed [10:0] n4_f;

    assign n4_f = $signed({1'b0, r3_f});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_dx    <= r3_dx;
            r4_dy    <= r3_dy;
            r4_px    <= r3_vx * n4_f;
            r4_py    <= r3_vy * n4_f;
            r4_vslow <= r3_vslow;
        end
    end

    // Stage 5: drop the eight fraction bits, rounding half away from zero.
    logic signed [32:0] r5_dx, r5_dy;
    logic signed [25:0] r5_svx, r5_svy;
    logic               r5_vslow;
    logic [34:0]        n5_apx, n5_apy, n5_rx, n5_ry;
    logic signed [25:0] n5_mx, n5_my;

    always_comb begin
        n5_apx = r4_px[34] ? 35'(-r4_px) : 35'(r4_px);
        n5_apy = r4_py[34] ? 35'(-r4_py) : 35'(r4_py);
        n5_rx  = (n5_apx + 35'd128) >> 8;
        n5_ry  = (n5_apy + 35'd128) >> 8;
        n5_mx  = $signed({1'b0, n5_rx[24:0]});
        n5_my  = $signed({1'b0, n5_ry[24:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_dx    <= r4_dx;
            r5_dy    <= r4_dy;
            r5_svx   <= r4_px[34] ? -n5_mx : n5_mx;
            r5_svy   <= r4_py[34] ? -n5_my : n5_my;
            r5_vslow <= r4_vslow;
        end
    end

    // Stage 6: plain differences and the residual error left after the prediction.
    t_pred_bus r6_bus;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_bus.dx    <= D_W'(r5_dx);
            r6_bus.dy    <= D_W'(r5_dy);
            r6_bus.pdx   <= D_W'(r5_dx) - D_W'(r5_svx);
            r6_bus.pdy   <= D_W'(r5_dy) - D_W'(r5_svy);
            r6_bus.vslow <= r5_vslow;
        end
    end

    assign o_bus = r6_bus;

endmodule

// ===== src/pdpe_select.sv =====
// Choice between plain and predicted difference, mode decision, quantisation.
// Four register stages; depends on pdpe_pkg.
module pdpe_select (
    input  logic                i_clk,
    input  logic                i_en,
    input  pdpe_pkg::t_pred_bus i_bus,
    input  logic                i_key,
    output pdpe_pkg::t_sel_bus  o_bus
);
    import pdpe_pkg::*;

    function automatic logic [D_W-1:0] f_abs(input logic signed [D_W-1:0] v);
        return v[D_W-1] ? D_W'(-v) : D_W'(v);
    endfunction

    // Stage 7: magnitudes and signs of all four differences.
    logic [D_W-1:0] r7_adx, r7_ady, r7_apx, r7_apy;
    logic           r7_ndx, r7_ndy, r7_npx, r7_npy;
    logic           r7_key, r7_vslow;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_adx   <= f_abs(i_bus.dx);
            r7_ady   <= f_abs(i_bus.dy);
            r7_apx   <= f_abs(i_bus.pdx);
            r7_apy   <= f_abs(i_bus.pdy);
            r7_ndx   <= i_bus.dx[D_W-1];
            r7_ndy   <= i_bus.dy[D_W-1];
            r7_npx   <= i_bus.pdx[D_W-1];
            r7_npy   <= i_bus.pdy[D_W-1];
            r7_key   <= i_key;
            r7_vslow <= i_bus.vslow;
        end
    end

    // Stage 8: prediction wins only on a strictly smaller L1 error.
    logic [D_W-1:0] r8_ax, r8_ay;
    logic           r8_nx, r8_ny, r8_pred, r8_key, r8_vslow;
    logic [D_W:0]   n8_sum_d, n8_sum_p;
    logic           n8_pred;

    always_comb begin
        n8_sum_d = {1'b0, r7_adx} + {1'b0, r7_ady};
        n8_sum_p = {1'b0, r7_apx} + {1'b0, r7_apy};
        n8_pred  = n8_sum_p < n8_sum_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_ax    <= n8_pred ? r7_apx : r7_adx;
            r8_ay    <= n8_pred ? r7_apy : r7_ady;
            r8_nx    <= n8_pred ? r7_npx : r7_ndx;
            r8_ny    <= n8_pred ? r7_npy : r7_ndy;
            r8_pred  <= n8_pred;
            r8_key   <= r7_key;
            r8_vslow <= r7_vslow;
        end
    end

    // Stage 9: mode from the thresholds; add half a step before dividing by ten.
    t_mode          r9_mode;
    logic           r9_pred, r9_key, r9_nx, r9_ny;
    logic [19:0]    r9_sx, r9_sy;
    t_mode          n9_mode;
    logic [D_W-1:0] n9_zthr;

    always_comb begin
        n9_zthr = r8_vslow ? D_W'(ZTHR_SLOW) : D_W'(ZTHR_FAST);
        if (r8_key) begin
            n9_mode = MODE_KEY;
        end else if (r8_ax < n9_zthr && r8_ay < n9_zthr) begin
            n9_mode = MODE_ZERO;
        end else if (r8_ax < D8_LIMIT && r8_ay < D8_LIMIT) begin
            n9_mode = MODE_D8;
        end else if (r8_ax < D16_LIMIT && r8_ay < D16_LIMIT) begin
            n9_mode = MODE_D16;
        end else begin
            n9_mode = MODE_KEY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_mode <= n9_mode;
            r9_pred <= r8_pred;
            r9_key  <= r8_key;
            r9_nx   <= r8_nx;
            r9_ny   <= r8_ny;
            r9_sx   <= {1'b0, r8_ax[18:0]} + 20'(ROUND_HALF);
            r9_sy   <= {1'b0, r8_ay[18:0]} + 20'(ROUND_HALF);
        end
    end

    // Stage 10: divide by ten through the reciprocal. In the delta modes the
    // magnitude stays below the saturation limits, so no clamp is needed.
    t_sel_bus    r10_bus;
    logic [38:0] n10_px, n10_py;

    always_comb begin
        n10_px = r9_sx * Q10_RECIP;
        n10_py = r9_sy * Q10_RECIP;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r10_bus.mode <= r9_mode;
            r10_bus.pred <= r9_pred;
            r10_bus.key  <= r9_key;
            r10_bus.qx   <= n10_px[Q10_SHIFT +: 15];
            r10_bus.qy   <= n10_py[Q10_SHIFT +: 15];
            r10_bus.negx <= r9_nx;
            r10_bus.negy <= r9_ny;
        end
    end

    assign o_bus = r10_bus;

endmodule

// ===== src/position_delta_packet_encoder_top.sv =====
// Top level of the position delta packet encoder: configuration, pipeline control,
// packet assembly. Depends on pdpe_pkg, pdpe_if, pdpe_key_div, pdpe_predict, pdpe_select.
//
// Use: position updates arrive as beats on i_pkt, one encoded packet per beat
// leaves on o_pkt. Each beat carries the current and last position, the last
// velocity, sequence number, timestamp, keyframe request and frame time; the
// packet beat carries status, length, flags, header copies and two payload words.
// The pipeline takes one beat every cycle unless the receiver stalls; throughput
// is then one packet per cycle, with eleven register stages (prediction
// multipliers, sequence remainder, division by ten) that each hold one item.
// When the receiver stalls with a packet waiting, all stages hold and i_pkt.ready
// falls in the same cycle; nothing is dropped or repeated. A bubble in the output
// register lets the pipeline move on.
// Reset clears every stage valid bit and sets the keyframe interval to 30 and
// the output capacity to 16 bytes. Registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while no item is in flight (not enforced by the block).
`include "position_delta_packet_encoder_top_assert.svh"

module position_delta_packet_encoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pdpe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pdpe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pdpe_in_if.sink                          i_pkt,
    pdpe_out_if.source                       o_pkt
);
    import pdpe_pkg::*;

    localparam int DEPTH = 11;
    localparam int SIDE_DEPTH = DEPTH - 1;

    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] ts;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
    } t_side;

    typedef struct packed {
        logic        status;
        logic [4:0]  packet_length;
        logic [3:0]  flags;
        logic [15:0] out_sequence;
        logic [31:0] out_timestamp;
        logic [31:0] payload_x;
        logic [31:0] payload_y;
    } t_out;

    // Configuration registers.
    logic [15:0] r_key_int;
    logic [4:0]  r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_int <= KEY_INTERVAL_RST;
            r_cap     <= OUT_CAPACITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_INTERVAL: r_key_int <= i_cfg_data[15:0];
                REG_OUT_CAPACITY: r_cap     <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Pipeline control: every stage moves unless a finished packet is held.
    logic [DEPTH-1:0] r_vld;
    logic             en;

    assign en          = !r_vld[DEPTH-1] || o_pkt.ready;
    assign i_pkt.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_pkt.valid};
        end
    end

    // Header fields and raw positions travel alongside the arithmetic.
    t_side r_side [SIDE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{seq: i_pkt.sequence_req, ts: i_pkt.timestamp,
                           pos_x: i_pkt.pos_x, pos_y: i_pkt.pos_y};
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Keyframe decision from the sequence number, aligned to the prediction output.
    logic key4;
    logic r_key5, r_key6;

    pdpe_key_div u_key_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_seq      (i_pkt.sequence_req),
        .i_force    (i_pkt.force_key),
        .i_interval (r_key_int),
        .o_key      (key4)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_key5 <= key4;
            r_key6 <= r_key5;
        end
    end

    // Prediction and selection stages.
    t_pred_bus pred_bus;
    t_sel_bus  sel_bus;

    pdpe_predict u_predict (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_pos_x         (i_pkt.pos_x),
        .i_pos_y         (i_pkt.pos_y),
        .i_last_x        (i_pkt.last_x),
        .i_last_y        (i_pkt.last_y),
        .i_vel_x         (i_pkt.vel_x),
        .i_vel_y         (i_pkt.vel_y),
        .i_frame_time_us (i_pkt.frame_time_us),
        .o_bus           (pred_bus)
    );

    pdpe_select u_select (
        .i_clk (i_clk),
        .i_en  (en),
        .i_bus (pred_bus),
        .i_key (r_key6),
        .o_bus (sel_bus)
    );

    // Output stage: signed payload words, length, capacity check.
    t_out        r_out;
    t_out        n_out;
    t_side       side;
    logic [15:0] sx, sy;
    logic [4:0]  len;

    always_comb begin
        side = r_side[SIDE_DEPTH-1];
        sx   = sel_bus.negx ? 16'(-{1'b0, sel_bus.qx}) : {1'b0, sel_bus.qx};
        sy   = sel_bus.negy ? 16'(-{1'b0, sel_bus.qy}) : {1'b0, sel_bus.qy};
        len  = f_mode_len(sel_bus.mode);

        n_out.status        = 1'b0;
        n_out.packet_length = len;
        n_out.flags         = {sel_bus.key, sel_bus.pred, sel_bus.mode};
        n_out.out_sequence  = side.seq;
        n_out.out_timestamp = side.ts;
        case (sel_bus.mode)
            MODE_KEY: begin
                n_out.payload_x = side.pos_x;
                n_out.payload_y = side.pos_y;
            end
            MODE_D16: begin
                n_out.payload_x = {16'b0, sx};
                n_out.payload_y = {16'b0, sy};
            end
            MODE_D8: begin
                n_out.payload_x = {24'b0, sx[7:0]};
                n_out.payload_y = {24'b0, sy[7:0]};
            end
            default: begin
                n_out.payload_x = '0;
                n_out.payload_y = '0;
            end
        endcase

        // Too little room: only the status survives.
        if (r_cap < len) begin
            n_out        = '0;
            n_out.status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_pkt.valid         = r_vld[DEPTH-1];
    assign o_pkt.status        = r_out.status;
    assign o_pkt.packet_length = r_out.packet_length;
    assign o_pkt.flags         = r_out.flags;
    assign o_pkt.out_sequence  = r_out.out_sequence;
    assign o_pkt.out_timestamp = r_out.out_timestamp;
    assign o_pkt.payload_x     = r_out.payload_x;
    assign o_pkt.payload_y     = r_out.payload_y;

    // A capacity error clears every other field of the packet.
    `PDPE_ASSERT_IMP(a_err_clears, i_clk, i_rst_n, r_vld[DEPTH-1] && r_out.status, r_out.packet_length == '0 && r_out.flags == '0 && r_out.payload_x == '0 && r_out.payload_y == '0)
    // A good packet has the length of its mode and fits the capacity.
    `PDPE_ASSERT_IMP(a_len_fits, i_clk, i_rst_n, r_vld[DEPTH-1] && !r_out.status, r_out.packet_length == f_mode_len(t_mode'(r_out.flags[1:0])) && r_out.packet_length <= r_cap)
    // A keyframe flag always comes with keyframe mode.
    `PDPE_ASSERT_IMP(a_key_mode, i_clk, i_rst_n, r_vld[DEPTH-1] && !r_out.status && r_out.flags[3], r_out.flags[1:0] == MODE_KEY)
    // A held packet freezes every stage.
    `PDPE_ASSERT_NXT(a_stall_freeze, i_clk, i_rst_n, r_vld[DEPTH-1] && !o_pkt.ready, $stable(r_vld))

endmodule
